// ----- rtl/rwcp_pkg.sv -----
`default_nettype none

package rwcp_pkg;

  // Parse phases, in the order a well-formed file walks them.
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_FMT_HDR   = 3'd1,
    PH_FMT_SKIP  = 3'd2,
    PH_FMT_BODY  = 3'd3,
    PH_DATA_HDR  = 3'd4,
    PH_DATA_SKIP = 3'd5,
    PH_DATA      = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_NO_FMT     = 3'd3,
    ST_NO_DATA    = 3'd4,
    ST_TRUNC      = 3'd5
  } status_t;

  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;  // "data"

  localparam logic [4:0] HDR_LAST_OFF = 5'd11;
  localparam logic [4:0] FMT_OFF_SAT  = 5'd16;

  // One request held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result offered to the result register.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [7:0]  audio_byte;
    logic        last_audio;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
  } result_t;

  // Expected file header byte: "RIFF", four size bytes, "WAVE".
  function automatic logic [7:0] hdr_expect(input logic [3:0] off);
    logic [7:0] b;
    unique case (off)
      4'd0:       b = 8'h52;  // R
      4'd1:       b = 8'h49;  // I
      4'd2, 4'd3: b = 8'h46;  // F
      4'd8:       b = 8'h57;  // W
      4'd9:       b = 8'h41;  // A
      4'd10:      b = 8'h56;  // V
      4'd11:      b = 8'h45;  // E
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // The RIFF size field is not checked.
  function automatic logic hdr_care(input logic [3:0] off);
    return (off < 4'd4) || (off > 4'd7);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rwcp_ifs.sv -----
`default_nettype none

interface rwcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rwcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  audio_byte;
  logic        last_audio;
  logic [31:0] sample_rate;
  logic [15:0] channel_count;
  logic [15:0] sample_bits;

  modport source (
    output valid, output status, output audio_byte, output last_audio,
    output sample_rate, output channel_count, output sample_bits, input ready
  );
  modport sink (
    input valid, input status, input audio_byte, input last_audio,
    input sample_rate, input channel_count, input sample_bits, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/rwcp_in_stage.sv -----
`default_nettype none

module rwcp_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  rwcp_in_if.sink             in_ch,
  input  wire logic           advance,
  output rwcp_pkg::item_t     item
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  // Take a new request when the register is empty or the held one leaves this cycle.
  assign in_ch.ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
  end

  assign item.valid     = valid_r;
  assign item.data_byte = data_r;
  assign item.last_byte = last_r;

endmodule

`default_nettype wire

// ----- rtl/rwcp_parse_core.sv -----
`default_nettype none

module rwcp_parse_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rwcp_pkg::item_t item,
  input  wire logic           advance,
  output rwcp_pkg::result_t   res
);

  rwcp_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  offset_r, offset_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic        step;
  logic [7:0]  b;
  logic [3:0]  hdr_off;
  logic        hdr_bad;
  logic [2:0]  ch_off;
  logic        ch_done;
  logic [31:0] ch_tag;
  logic [31:0] ch_len;
  logic [31:0] left_dec;
  logic        left_end;
  logic        emit;
  rwcp_pkg::status_t status;
  logic [7:0]  audio;
  logic        last_a;
  logic        early_end;

  assign step = item.valid && advance;
  assign b    = item.data_byte;

  // Shared decode of the byte against the current position.
  always_comb begin
    hdr_off  = (offset_r < 5'd12) ? offset_r[3:0] : rwcp_pkg::HDR_LAST_OFF[3:0];
    hdr_bad  = rwcp_pkg::hdr_care(hdr_off) && (b != rwcp_pkg::hdr_expect(hdr_off));
    ch_off   = offset_r[2:0];
    ch_done  = (ch_off == 3'd7);
    if (ch_off[2] == 1'b0) begin
      ch_tag = {tag_r[23:0], b};
      ch_len = (ch_off == 3'd0) ? 32'd0 : len_r;
    end else begin
      ch_tag = tag_r;
      ch_len = len_r | ({24'd0, b} << {ch_off[1:0], 3'b000});
    end
    left_dec = left_r - 32'd1;
    left_end = (left_dec == 32'd0);
  end

  // Next state.
  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    unique case (phase_r)
      rwcp_pkg::PH_HEADER: begin
        if (hdr_bad) begin
          phase_nxt = rwcp_pkg::PH_DONE;
        end else if ({1'b0, hdr_off} == rwcp_pkg::HDR_LAST_OFF) begin
          offset_nxt = 5'd0;
          phase_nxt  = rwcp_pkg::PH_FMT_HDR;
        end else begin
          offset_nxt = {1'b0, hdr_off} + 5'd1;
        end
      end
      rwcp_pkg::PH_FMT_HDR, rwcp_pkg::PH_DATA_HDR: begin
        tag_nxt    = ch_tag;
        len_nxt    = ch_len;
        offset_nxt = ch_done ? 5'd0 : {2'b00, ch_off} + 5'd1;
        if (ch_done) begin
          left_nxt = ch_len;
          if (phase_r == rwcp_pkg::PH_FMT_HDR) begin
            if (ch_tag == rwcp_pkg::TAG_FMT) begin
              phase_nxt = (ch_len == 32'd0) ? rwcp_pkg::PH_DATA_HDR : rwcp_pkg::PH_FMT_BODY;
            end else if (ch_len != 32'd0) begin
              phase_nxt = rwcp_pkg::PH_FMT_SKIP;
            end
          end else begin
            if (ch_tag == rwcp_pkg::TAG_DATA) begin
              phase_nxt = (ch_len == 32'd0) ? rwcp_pkg::PH_DONE : rwcp_pkg::PH_DATA;
            end else if (ch_len != 32'd0) begin
              phase_nxt = rwcp_pkg::PH_DATA_SKIP;
            end
          end
        end
      end
      rwcp_pkg::PH_FMT_SKIP: begin
        left_nxt = left_dec;
        if (left_end) phase_nxt = rwcp_pkg::PH_FMT_HDR;
      end
      rwcp_pkg::PH_DATA_SKIP: begin
        left_nxt = left_dec;
        if (left_end) phase_nxt = rwcp_pkg::PH_DATA_HDR;
      end
      rwcp_pkg::PH_FMT_BODY: begin
        left_nxt = left_dec;
        if (offset_r < rwcp_pkg::FMT_OFF_SAT) offset_nxt = offset_r + 5'd1;
        if (left_end) begin
          offset_nxt = 5'd0;
          phase_nxt  = rwcp_pkg::PH_DATA_HDR;
        end
      end
      rwcp_pkg::PH_DATA: begin
        left_nxt = left_dec;
        if (left_end) phase_nxt = rwcp_pkg::PH_DONE;
      end
      rwcp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Format fields and result.
  always_comb begin
    rate_nxt = rate_r;
    chan_nxt = chan_r;
    bits_nxt = bits_r;
    emit     = 1'b0;
    status   = rwcp_pkg::ST_DATA;
    audio    = 8'd0;
    last_a   = 1'b0;
    unique case (phase_r)
      rwcp_pkg::PH_HEADER: begin
        if (hdr_bad) begin
          emit   = 1'b1;
          status = rwcp_pkg::ST_BAD_HEADER;
          last_a = 1'b1;
        end
      end
      rwcp_pkg::PH_FMT_HDR: begin
        if (ch_done && ch_tag == rwcp_pkg::TAG_FMT) begin
          rate_nxt = 32'd0;
          chan_nxt = 16'd0;
          bits_nxt = 16'd0;
        end
      end
      rwcp_pkg::PH_FMT_BODY: begin
        case (offset_r)
          5'd2:  chan_nxt[7:0]   = b;
          5'd3:  chan_nxt[15:8]  = b;
          5'd4:  rate_nxt[7:0]   = b;
          5'd5:  rate_nxt[15:8]  = b;
          5'd6:  rate_nxt[23:16] = b;
          5'd7:  rate_nxt[31:24] = b;
          5'd14: bits_nxt[7:0]   = b;
          5'd15: bits_nxt[15:8]  = b;
          default: begin
          end
        endcase
      end
      rwcp_pkg::PH_DATA_HDR: begin
        if (ch_done && ch_tag == rwcp_pkg::TAG_DATA && ch_len == 32'd0) begin
          emit   = 1'b1;
          status = rwcp_pkg::ST_EMPTY;
          last_a = 1'b1;
        end
      end
      rwcp_pkg::PH_DATA: begin
        emit   = 1'b1;
        audio  = b;
        last_a = left_end;
      end
      default: begin
      end
    endcase

    // End of file before the data body completes: report what is missing.
    early_end = item.last_byte && (!emit || (status == rwcp_pkg::ST_DATA && !last_a))
                && (phase_nxt != rwcp_pkg::PH_DONE);
    if (early_end) begin
      emit   = 1'b1;
      audio  = 8'd0;
      last_a = 1'b1;
      case (phase_nxt)
        rwcp_pkg::PH_HEADER:                          status = rwcp_pkg::ST_BAD_HEADER;
        rwcp_pkg::PH_FMT_HDR, rwcp_pkg::PH_FMT_SKIP:  status = rwcp_pkg::ST_NO_FMT;
        rwcp_pkg::PH_DATA:                            status = rwcp_pkg::ST_TRUNC;
        default:                                      status = rwcp_pkg::ST_NO_DATA;
      endcase
    end
  end

  assign res.valid         = step && emit;
  assign res.status        = status;
  assign res.audio_byte    = audio;
  assign res.last_audio    = last_a;
  assign res.sample_rate   = rate_nxt;
  assign res.channel_count = chan_nxt;
  assign res.sample_bits   = bits_nxt;

  // The last byte of a file rearms everything.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r  <= rwcp_pkg::PH_HEADER;
      offset_r <= 5'd0;
      tag_r    <= 32'd0;
      len_r    <= 32'd0;
      left_r   <= 32'd0;
      rate_r   <= 32'd0;
      chan_r   <= 16'd0;
      bits_r   <= 16'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      tag_r    <= tag_nxt;
      len_r    <= len_nxt;
      left_r   <= left_nxt;
      rate_r   <= rate_nxt;
      chan_r   <= chan_nxt;
      bits_r   <= bits_nxt;
    end
  end

`ifndef SYNTH
  a_data_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == rwcp_pkg::ST_DATA) |-> (phase_r == rwcp_pkg::PH_DATA))
    else $error("data byte emitted outside the data body");

  a_rearm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last_byte) |=> (phase_r == rwcp_pkg::PH_HEADER && offset_r == 5'd0))
    else $error("parser not rearmed after last byte");

  a_header_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rwcp_pkg::PH_HEADER) |-> (offset_r < 5'd12))
    else $error("header offset out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/rwcp_out_stage.sv -----
`default_nettype none

module rwcp_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rwcp_pkg::result_t res,
  rwcp_out_if.source          out_ch,
  output logic                advance
);

  logic              valid_r;
  rwcp_pkg::result_t data_r;

  // Move on when the result register is empty or being drained.
  assign advance = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      data_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = data_r.status;
  assign out_ch.audio_byte    = data_r.audio_byte;
  assign out_ch.last_audio    = data_r.last_audio;
  assign out_ch.sample_rate   = data_r.sample_rate;
  assign out_ch.channel_count = data_r.channel_count;
  assign out_ch.sample_bits   = data_r.sample_bits;

`ifndef SYNTH
  a_terminal_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r.status != rwcp_pkg::ST_DATA) |-> data_r.last_audio)
    else $error("terminal status without last_audio");
`endif

endmodule

`default_nettype wire

// ----- rtl/riff_wave_chunk_parser.sv -----
`default_nettype none

// RIFF/WAVE stream parser.
// in_ch carries the file one byte per request (data_byte, last_byte set on the
// final byte of the file). out_ch carries zero or one result per byte: the
// audio bytes of the "data" chunk with status 0, or one terminal status (empty
// data chunk, bad header, no fmt, no data, truncated), each tagged with the
// sample rate, channel count and bits per sample latched from the "fmt " chunk.
// last_audio marks the final data byte and every terminal status.
// A byte accepted from in_ch is held in the input register, parsed, and its
// result is held in the result register. Throughput: one byte per cycle while
// the receiver takes results, set by the combinational parse step between them.
// Header bytes, skipped chunks and bytes after the data chunk give no result.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the file header check; a byte with last_byte set also returns the parser
// to that check after it is parsed, so the next byte starts a new file.
// When the receiver stalls, the result register holds, the input register
// holds its byte, and in_ch.ready drops until the result is taken.
module riff_wave_chunk_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rwcp_in_if.sink     in_ch,
  rwcp_out_if.source  out_ch
);

  rwcp_pkg::item_t   item;
  rwcp_pkg::result_t res;
  logic              advance;

  // Hold the accepted byte until the parse step can take it.
  rwcp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .item    (item)
  );

  // Advance the chunk walk and form the result.
  rwcp_parse_core u_parse_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  // Register the result for the receiver.
  rwcp_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .res     (res),
    .out_ch  (out_ch),
    .advance (advance)
  );

endmodule

`default_nettype wire
